// ===== sv/cmix_pkg.sv =====
// shared types, constants and helpers for the column prefix mixer
// no dependencies; imported by every module of the block
package cmix_pkg;

	// channel count and widths of the running prefix values
	localparam int N  = 4;
	localparam int IW = (N > 1) ? $clog2(N) : 1;
	localparam int TW = 23;   // prefix total, signed
	localparam int CW = 19;   // prefix count, signed
	localparam int NW = 33;   // magnitude of total scaled by 1.0
	localparam int DW = CW - 1;
	localparam int QW = 17;   // quotient bits kept before saturation
	localparam int SW = NW + 1;

	// configuration register indexes
	localparam logic [1:0] REG_AVERAGE  = 2'd0;
	localparam logic [1:0] REG_WEIGHTED = 2'd1;
	localparam logic [1:0] REG_NEG_WGT  = 2'd2;

	localparam logic [15:0] SAT_MAX = 16'h7fff;
	localparam logic [15:0] SAT_MIN = 16'h8000;

	typedef logic signed [15:0] smp_t;

	typedef struct packed {
		logic avg;
		logic wgt;
		logic neg;
	} cfg_t;

	// one frame as it travels down the chain of prefix cells
	typedef struct packed {
		smp_t [N-1:0]             sig;
		smp_t [N-1:0]             up;
		logic [N-1:0]             conn;
		logic [N-1:0][TW-1:0]     tot;
		logic [N-1:0][CW-1:0]     cnt;
	} frame_t;

	// one channel inside the divider chain
	typedef struct packed {
		logic [NW-1:0] rem;
		logic [SW-1:0] dsh;
		logic [QW-1:0] q;
		logic          neg;
		logic          ovf;
		logic          zro;
		logic [15:0]   pass;
	} div_t;

	typedef div_t [N-1:0] div_row_t;

	// clip a prefix total to 16 bits
	function automatic logic [15:0] sat16(input logic [TW-1:0] v);
		logic signed [TW-1:0] s;
		begin
			s = $signed(v);
			if (s > $signed(TW'(32767)))
				sat16 = SAT_MAX;
			else if (s < -$signed(TW'(32768)))
				sat16 = SAT_MIN;
			else
				sat16 = v[15:0];
		end
	endfunction

endpackage

// ===== sv/cmix_cell.sv =====
// prefix cell: adds one channel to the running total and count
// depends on cmix_pkg
module cmix_cell import cmix_pkg::*; (
	input  logic            clk,
	input  logic            en,
	input  logic [IW-1:0]   idx,
	input  cfg_t            cfg,
	input  frame_t          fr_i,
	output frame_t          fr_q
);

	logic signed [15:0]   s;
	logic signed [15:0]   u;
	logic signed [31:0]   prod;
	logic signed [31:0]   prod_fl;
	logic signed [16:0]   sum;
	logic signed [16:0]   w;
	logic [IW-1:0]        idx_p;
	logic signed [TW-1:0] tin;
	logic signed [CW-1:0] cin;
	logic signed [TW-1:0] tadd;
	logic signed [CW-1:0] cadd;
	logic signed [TW-1:0] tot_n;
	logic signed [CW-1:0] cnt_n;
	frame_t               fr_n;

	// contribution of this channel
	always_comb begin
		s       = $signed(fr_i.sig[idx]);
		u       = $signed(fr_i.up[idx]);
		idx_p   = idx - IW'(1);
		tin     = (idx == '0) ? '0 : $signed(fr_i.tot[idx_p]);
		cin     = (idx == '0) ? '0 : $signed(fr_i.cnt[idx_p]);
		prod    = s * u;
		prod_fl = prod >>> 11;
		sum     = {s[15], s} + {u[15], u};
		w       = (cfg.neg || !u[15]) ? {u[15], u} : -{u[15], u};
		if (cfg.wgt)
			tadd = prod_fl[TW-1:0];
		else
			tadd = {{(TW-17){sum[16]}}, sum};
		cadd = '0;
		if (fr_i.conn[idx]) begin
			if (cfg.wgt)
				cadd = {{(CW-17){w[16]}}, w};
			else if (u != 16'sd0)
				cadd = CW'(2048);
		end
		if (!cfg.wgt && s != 16'sd0)
			cadd = cadd + CW'(2048);
		tot_n = tin + tadd;
		cnt_n = cin + cadd;
		// new prefix goes in this channel's slot
		fr_n          = fr_i;
		fr_n.tot[idx] = tot_n;
		fr_n.cnt[idx] = cnt_n;
	end

	// stage register
	always_ff @(posedge clk) begin
		if (en)
			fr_q <= fr_n;
	end

endmodule

// ===== sv/cmix_div_cell.sv =====
// divider cell: one restoring quotient bit for every channel
// depends on cmix_pkg
module cmix_div_cell import cmix_pkg::*; (
	input  logic     clk,
	input  logic     en,
	input  div_row_t d_i,
	output div_row_t d_q
);

	div_row_t d_n;
	logic [N-1:0] ge;

	// compare and subtract the shifted divisor
	always_comb begin
		for (int c = 0; c < N; c++) begin
			d_n[c]     = d_i[c];
			ge[c]      = {1'b0, d_i[c].rem} >= d_i[c].dsh;
			if (ge[c])
				d_n[c].rem = d_i[c].rem - d_i[c].dsh[NW-1:0];
			d_n[c].q   = {d_i[c].q[QW-2:0], ge[c]};
			d_n[c].dsh = d_i[c].dsh >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			d_q <= d_n;
	end

endmodule

// ===== sv/column_prefix_mixer.sv =====
// top level of the column prefix mixer
// depends on cmix_pkg, cmix_cell and cmix_div_cell
//
// Takes one frame of four channels per clock and returns every channel's
// prefix result through 4 prefix cells, one divider set-up stage,
// 17 divider cells and one output register. The chain of prefix cells and
// the restoring divider chain are fully pipelined, so a new frame can be
// taken in each cycle; a stall on the output holds the whole pipeline.
// Configuration writes take effect at once and belong to an idle block.
module column_prefix_mixer import cmix_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] signal_0,
	input  logic [15:0] signal_1,
	input  logic [15:0] signal_2,
	input  logic [15:0] signal_3,
	input  logic [15:0] upstream_0,
	input  logic [15:0] upstream_1,
	input  logic [15:0] upstream_2,
	input  logic [15:0] upstream_3,
	input  logic [3:0]  upstream_connected,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] downstream_0,
	output logic [15:0] downstream_1,
	output logic [15:0] downstream_2,
	output logic [15:0] downstream_3,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data
);

	localparam int NSTEP = QW;
	localparam int L     = N + NSTEP + 2;

	cfg_t              cfg_q;
	logic              en;
	logic [L-1:0]      vld_q;
	frame_t            fr [N+1];
	div_row_t          dv [NSTEP+1];
	div_row_t          prep_n;
	logic [N-1:0][15:0] res_n;
	logic [N-1:0][15:0] out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AVERAGE:  cfg_q.avg <= cfg_data;
				REG_WEIGHTED: cfg_q.wgt <= cfg_data;
				REG_NEG_WGT:  cfg_q.neg <= cfg_data;
				default:      cfg_q     <= cfg_q;
			endcase
		end
	end

	// whole pipeline advances unless a finished beat is held
	assign en       = !vld_q[L-1] || !out_stall;
	assign in_stall = !en;
	assign out_valid = vld_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[L-2:0], in_valid};
	end

	// incoming beat as a frame
	always_comb begin
		fr[0]      = '0;
		fr[0].sig  = {signal_3, signal_2, signal_1, signal_0};
		fr[0].up   = {upstream_3, upstream_2, upstream_1, upstream_0};
		fr[0].conn = upstream_connected;
	end

	// chain of prefix cells
	for (genvar k = 0; k < N; k++) begin : g_cell
		cmix_cell u_cell (
			.clk  (clk),
			.en   (en),
			.idx  (IW'(k)),
			.cfg  (cfg_q),
			.fr_i (fr[k]),
			.fr_q (fr[k+1])
		);
	end

	// divider set-up: magnitudes, sign, zero count, overflow and plain result
	always_comb begin
		for (int c = 0; c < N; c++) begin
			logic [TW-1:0] t;
			logic [CW-1:0] n;
			logic [TW-1:0] mt;
			logic [CW-1:0] mc;
			t  = fr[N].tot[c];
			n  = fr[N].cnt[c];
			mt = t[TW-1] ? -t : t;
			mc = n[CW-1] ? -n : n;
			prep_n[c].rem  = {mt[TW-2:0], 11'b0};
			prep_n[c].dsh  = {mc[DW-1:0], 16'b0};
			prep_n[c].q    = '0;
			prep_n[c].neg  = t[TW-1] ^ n[CW-1];
			prep_n[c].zro  = (n == '0);
			prep_n[c].ovf  = {2'b0, mt[TW-2:0], 11'b0} >= {mc[DW-1:0], 17'b0};
			prep_n[c].pass = sat16(t);
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			dv[0] <= prep_n;
	end

	// chain of divider cells
	for (genvar j = 0; j < NSTEP; j++) begin : g_div
		cmix_div_cell u_div (
			.clk (clk),
			.en  (en),
			.d_i (dv[j]),
			.d_q (dv[j+1])
		);
	end

	// signed, saturated quotient or plain total
	always_comb begin
		for (int c = 0; c < N; c++) begin
			div_t d;
			d = dv[NSTEP][c];
			if (!cfg_q.avg)
				res_n[c] = d.pass;
			else if (d.zro)
				res_n[c] = '0;
			else if (d.ovf)
				res_n[c] = d.neg ? SAT_MIN : SAT_MAX;
			else if (d.neg)
				res_n[c] = (d.q > QW'(32768)) ? SAT_MIN : -d.q[15:0];
			else
				res_n[c] = (d.q > QW'(32767)) ? SAT_MAX : d.q[15:0];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en)
			out_q <= res_n;
	end

	assign downstream_0 = out_q[0];
	assign downstream_1 = out_q[1];
	assign downstream_2 = out_q[2];
	assign downstream_3 = out_q[3];

endmodule

// ===== dv/column_prefix_mixer_chk.sv =====
// checker for the column prefix mixer: watches all four channels, predicts and compares
// depends on cmix_pkg for the register indexes
module column_prefix_mixer_chk import cmix_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [15:0] signal_0,
	input  logic [15:0] signal_1,
	input  logic [15:0] signal_2,
	input  logic [15:0] signal_3,
	input  logic [15:0] upstream_0,
	input  logic [15:0] upstream_1,
	input  logic [15:0] upstream_2,
	input  logic [15:0] upstream_3,
	input  logic [3:0]  upstream_connected,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] downstream_0,
	input  logic [15:0] downstream_1,
	input  logic [15:0] downstream_2,
	input  logic [15:0] downstream_3,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data,
	output int          errors,
	output int          pending
);

	typedef logic [3:0][15:0] mix_row_t;

	logic     avg_q, wgt_q, neg_q;
	mix_row_t mix_expected[$];

	assign pending = mix_expected.size();

	function automatic logic [15:0] clip16(input longint v);
		if (v > 32767)
			return 16'h7fff;
		if (v < -32768)
			return 16'h8000;
		return v[15:0];
	endfunction

	// prefix totals and counts over the four channels
	function automatic mix_row_t mix_frame(input logic [3:0][15:0] sig,
		input logic [3:0][15:0] up, input logic [3:0] conn);
		longint   total, count, s, u, p, r;
		mix_row_t row;
		total = 0;
		count = 0;
		for (int i = 0; i < 4; i++) begin
			s = longint'($signed(sig[i]));
			u = longint'($signed(up[i]));
			if (conn[i]) begin
				if (wgt_q)
					count += (neg_q || u >= 0) ? u : -u;
				else if (u != 0)
					count += 2048;
			end
			if (!wgt_q && s != 0)
				count += 2048;
			if (wgt_q) begin
				p = u * s;
				total += (p >= 0) ? p / 2048 : -((-p + 2047) / 2048);
			end else
				total += u + s;
			if (avg_q)
				r = (count != 0) ? (total * 2048) / count : 0;
			else
				r = total;
			row[i] = clip16(r);
		end
		return row;
	endfunction

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	initial errors = 0;

	// register shadow, input beats and output beats
	always @(posedge clk or negedge arst_n) begin
		mix_row_t got, exp_row;
		if (!arst_n) begin
			avg_q <= 1'b0;
			wgt_q <= 1'b0;
			neg_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_AVERAGE:  avg_q <= cfg_data;
					REG_WEIGHTED: wgt_q <= cfg_data;
					REG_NEG_WGT:  neg_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				mix_expected.push_back(mix_frame(
					{signal_3, signal_2, signal_1, signal_0},
					{upstream_3, upstream_2, upstream_1, upstream_0},
					upstream_connected));
			if (out_valid && !out_stall) begin
				got = {downstream_3, downstream_2, downstream_1, downstream_0};
				if (mix_expected.size() == 0)
					report("result beat with nothing expected");
				else begin
					exp_row = mix_expected.pop_front();
					for (int i = 0; i < 4; i++)
						if (got[i] !== exp_row[i])
							report($sformatf("downstream_%0d got %h expected %h",
								i, got[i], exp_row[i]));
				end
			end
		end
	end

endmodule

// ===== dv/column_prefix_mixer_tb.sv =====
// testbench top for the column prefix mixer: clock, reset, stimulus and verdict
// depends on cmix_pkg, column_prefix_mixer and column_prefix_mixer_chk
module column_prefix_mixer_tb import cmix_pkg::*;;

	logic        clk, arst_n;
	logic        in_valid, in_stall, out_valid, out_stall;
	logic [15:0] signal_0, signal_1, signal_2, signal_3;
	logic [15:0] upstream_0, upstream_1, upstream_2, upstream_3;
	logic [3:0]  upstream_connected;
	logic [15:0] downstream_0, downstream_1, downstream_2, downstream_3;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic        cfg_data;
	int          errors, pending;
	int          cycles;
	int          idle_pct;
	logic        hold_off;

	column_prefix_mixer i_dut (.*);
	column_prefix_mixer_chk i_chk (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("column_prefix_mixer verification failed");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off
	initial begin
		out_stall = 1'b0;
		hold_off = 1'b0;
	end
	always @(posedge clk)
		out_stall <= hold_off || ($urandom_range(99) < idle_pct);

	task automatic cfg_write(input logic [1:0] idx, input logic v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [15:0] rand_sample(input int kind);
		case (kind)
			0: return 16'h0000;
			1: return 16'h7fff;
			2: return 16'h8000;
			3: return 16'(($urandom_range(8) - 4) * 2048);
			4: return 16'($urandom_range(600)) - 16'd300;
			default: return 16'($urandom);
		endcase
	endfunction

	// one frame beat; idles at random before offering it
	task automatic send_frame(input logic [15:0] s0, s1, s2, s3, u0, u1, u2, u3,
		input logic [3:0] conn);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid           <= 1'b1;
		signal_0           <= s0;
		signal_1           <= s1;
		signal_2           <= s2;
		signal_3           <= s3;
		upstream_0         <= u0;
		upstream_1         <= u1;
		upstream_2         <= u2;
		upstream_3         <= u3;
		upstream_connected <= conn;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_random;
		send_frame(rand_sample($urandom_range(6)), rand_sample($urandom_range(6)),
			rand_sample($urandom_range(6)), rand_sample($urandom_range(6)),
			rand_sample($urandom_range(6)), rand_sample($urandom_range(6)),
			rand_sample($urandom_range(6)), rand_sample($urandom_range(6)),
			4'($urandom));
	endtask

	// drain the pipeline before touching the registers
	task automatic drain;
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	initial begin
		logic [15:0] dirs[4];
		in_valid = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_AVERAGE;
		cfg_data = 1'b0;
		{signal_0, signal_1, signal_2, signal_3} = '0;
		{upstream_0, upstream_1, upstream_2, upstream_3} = '0;
		upstream_connected = '0;
		idle_pct = 16;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, zero counts and saturation in every mode
		dirs = '{16'h0000, 16'h7fff, 16'h8000, 16'h0800};
		for (int m = 0; m < 8; m++) begin
			cfg_write(REG_AVERAGE, m[0]);
			cfg_write(REG_WEIGHTED, m[1]);
			cfg_write(REG_NEG_WGT, m[2]);
			send_frame('0, '0, '0, '0, '0, '0, '0, '0, 4'hf);
			send_frame(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
				16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 4'hf);
			send_frame(16'h8000, 16'h8000, 16'h8000, 16'h8000,
				16'h8000, 16'h8000, 16'h8000, 16'h8000, 4'hf);
			send_frame(dirs[1], dirs[2], 16'hffff, 16'h0001,
				dirs[3], 16'hf800, 16'h8000, 16'h7fff, 4'h5);
			send_frame(16'h0001, 16'hffff, 16'h0000, 16'h0800,
				16'hf800, 16'h0800, 16'hf800, 16'h0000, 4'ha);
			drain();
		end

		// random phases over every register setting
		for (int ph = 0; ph < 8; ph++) begin
			cfg_write(REG_AVERAGE, ph[0]);
			cfg_write(REG_WEIGHTED, ph[1]);
			cfg_write(REG_NEG_WGT, ph[2]);
			idle_pct = (ph == 3) ? 0 : 16;
			for (int k = 0; k < 210; k++) begin
				// long receiver hold-off so the block backs up
				if (ph == 5 && k == 20)
					fork
						begin
							hold_off = 1'b1;
							repeat (120) @(posedge clk);
							hold_off = 1'b0;
						end
					join_none
				// sender pause until everything is back
				if (ph == 6 && k == 100) begin
					in_valid <= 1'b0;
					while (pending != 0)
						@(posedge clk);
				end
				send_random();
			end
			drain();
		end

		if (errors == 0)
			$display("column_prefix_mixer verification clean");
		else
			$display("column_prefix_mixer verification failed");
		$finish;
	end

endmodule
